// ===== hw/rtl/hssc_pkg.sv =====
// Shared types, constants and lookup functions for the hall six-step commutator.
`timescale 1ns / 1ps

package hssc_pkg;

  localparam int POSITION_BITS_DEFAULT = 32;
  localparam int DUTY_BITS_DEFAULT     = 16;

  localparam int APB_ADDR_BITS = 2;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_SPEED_WINDOW = 2'd0;

  localparam logic [15:0] SPEED_WINDOW_RESET = 16'd400;
  localparam logic [3:0]  HALL_NONE_SEEN     = 4'hF;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;
  localparam logic DIR_CCW      = 1'b0;
  localparam logic DIR_CW       = 1'b1;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_U    = 2'd1;
  localparam logic [1:0] PHASE_V    = 2'd2;
  localparam logic [1:0] PHASE_W    = 2'd3;

  localparam logic [2:0] STEP_OFF = 3'd0;
  localparam logic [2:0] STEP_MAX = 3'd6;

  // previous step in the high nibble, new step in the low nibble
  localparam logic [7:0] MOVES_CW  [6] = '{8'h62, 8'h23, 8'h31, 8'h15, 8'h54, 8'h46};
  localparam logic [7:0] MOVES_CCW [6] = '{8'h45, 8'h51, 8'h13, 8'h32, 8'h26, 8'h64};

  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_CW,
    MOVE_CCW
  } move_t;

  function automatic logic [1:0] pair_high(logic [2:0] step);
    logic [1:0] ph;
    case (step)
      3'd1:    ph = PHASE_U;
      3'd2:    ph = PHASE_V;
      3'd3:    ph = PHASE_V;
      3'd4:    ph = PHASE_W;
      3'd5:    ph = PHASE_U;
      3'd6:    ph = PHASE_W;
      default: ph = PHASE_NONE;
    endcase
    return ph;
  endfunction

  function automatic logic [1:0] pair_low(logic [2:0] step);
    logic [1:0] pl;
    case (step)
      3'd1:    pl = PHASE_W;
      3'd2:    pl = PHASE_U;
      3'd3:    pl = PHASE_W;
      3'd4:    pl = PHASE_V;
      3'd5:    pl = PHASE_V;
      3'd6:    pl = PHASE_U;
      default: pl = PHASE_NONE;
    endcase
    return pl;
  endfunction

  function automatic move_t classify_move(logic [2:0] from_step, logic [2:0] to_step);
    logic [7:0] key;
    move_t      mv;
    key = {1'b0, from_step, 1'b0, to_step};
    mv  = MOVE_NONE;
    if (from_step <= STEP_MAX && to_step <= STEP_MAX) begin
      for (int i = 0; i < 6; i++) begin
        if (key == MOVES_CW[i]) mv = MOVE_CW;
      end
      for (int i = 0; i < 6; i++) begin
        if (key == MOVES_CCW[i]) mv = MOVE_CCW;
      end
    end
    return mv;
  endfunction

endpackage

// ===== hw/rtl/hssc_in_if.sv =====
// Input channel: PWM ticks and drive commands with valid/ready handshake.
`timescale 1ns / 1ps

interface hssc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  hall_bits;
  logic        dir;
  logic [15:0] duty;

  modport source (output valid, output kind, output hall_bits, output dir, output duty,
                  input ready);
  modport sink   (input valid, input kind, input hall_bits, input dir, input duty,
                  output ready);
endinterface

// ===== hw/rtl/hssc_out_if.sv =====
// Result channel: switch pattern and motion status with valid/ready handshake.
`timescale 1ns / 1ps

interface hssc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         high_phase;
  logic [1:0]         low_phase;
  logic [15:0]        pwm_compare;
  logic               running;
  logic               hall_fault;
  logic [2:0]         step_now;
  logic signed [31:0] position;
  logic signed [31:0] speed;
  logic [15:0]        dwell_ticks;

  modport source (output valid, output high_phase, output low_phase, output pwm_compare,
                  output running, output hall_fault, output step_now, output position,
                  output speed, output dwell_ticks, input ready);
  modport sink   (input valid, input high_phase, input low_phase, input pwm_compare,
                  input running, input hall_fault, input step_now, input position,
                  input speed, input dwell_ticks, output ready);
endinterface

// ===== hw/rtl/hall_six_step_commutator.sv =====
// Hall six-step commutator: commutation, position, speed and dwell tracking.
//
//   channel  | dir | payload                                         | handshake
//   ---------+-----+-------------------------------------------------+----------
//   sample   | in  | kind, hall_bits, dir, duty                      | valid/ready
//   result   | out | high/low phase, compare, status, position, speed | valid/ready
//   apb      | in  | speed_window at byte address 0                  | psel/penable
//
// State and the result register update at the accepting edge,
// set by a single pass through the step mapping, table classify and position adder.
// A new transaction is taken every cycle while the result register is empty or being drained.
// Reset (rst, synchronous) stops the motor, clears counters and loads speed_window with 400.
// A stalled result holds the register and drops ready on the input side.
`timescale 1ns / 1ps

module hall_six_step_commutator #(
  parameter int POSITION_BITS = hssc_pkg::POSITION_BITS_DEFAULT,
  parameter int DUTY_BITS     = hssc_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  hssc_in_if.sink                            sample,
  hssc_out_if.source                         result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hssc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [hssc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [hssc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  // configuration
  logic [15:0] speed_window;

  // motor state
  logic                     run_mode, run_mode_next;
  logic                     direction, direction_next;
  logic [DUTY_BITS-1:0]     duty_value, duty_value_next;
  logic [3:0]               prev_hall, prev_hall_next;
  logic [2:0]               step_current, step_current_next;
  logic [2:0]               step_previous, step_previous_next;
  logic [2:0]               drive_pattern, drive_pattern_next;
  logic [POSITION_BITS-1:0] pos_count, pos_count_next;
  logic [POSITION_BITS-1:0] pos_snapshot, pos_snapshot_next;
  logic [POSITION_BITS-1:0] speed_value, speed_value_next;
  logic [15:0]              window_count, window_count_next;
  logic [15:0]              dwell_count, dwell_count_next;
  logic                     fault;

  logic                     res_valid;
  logic                     accept;

  logic [2:0]               mapped_step;
  logic [16:0]              window_inc;
  hssc_pkg::move_t          move;
  logic [DUTY_BITS-1:0]     cmd_duty;
  logic signed [63:0]       pos_ext;
  logic signed [63:0]       speed_ext;

  assign pready = 1'b1;
  assign prdata = (paddr == hssc_pkg::ADDR_SPEED_WINDOW) ?
                  hssc_pkg::APB_DATA_BITS'(speed_window) : '0;

  assign sample.ready = !res_valid || result.ready;
  assign accept       = sample.valid && sample.ready;
  assign result.valid = res_valid;

  assign cmd_duty   = sample.duty[DUTY_BITS-1:0];
  assign window_inc = {1'b0, window_count} + 17'd1;

  always_comb begin
    run_mode_next      = run_mode;
    direction_next     = direction;
    duty_value_next    = duty_value;
    prev_hall_next     = prev_hall;
    step_current_next  = step_current;
    step_previous_next = step_previous;
    drive_pattern_next = drive_pattern;
    pos_count_next     = pos_count;
    pos_snapshot_next  = pos_snapshot;
    speed_value_next   = speed_value;
    window_count_next  = window_count;
    dwell_count_next   = dwell_count;
    fault              = 1'b0;
    mapped_step        = hssc_pkg::STEP_OFF;
    move               = hssc_pkg::MOVE_NONE;

    if (sample.kind == hssc_pkg::KIND_COMMAND) begin
      direction_next = sample.dir;
      if (cmd_duty == '0) begin
        duty_value_next    = '0;
        run_mode_next      = 1'b0;
        drive_pattern_next = hssc_pkg::STEP_OFF;
      end else begin
        duty_value_next = cmd_duty;
        run_mode_next   = 1'b1;
        mapped_step     = (sample.dir == hssc_pkg::DIR_CW) ? ~sample.hall_bits
                                                           : sample.hall_bits;
        step_current_next = mapped_step;
        if (mapped_step != hssc_pkg::STEP_OFF && mapped_step <= hssc_pkg::STEP_MAX) begin
          drive_pattern_next = mapped_step;
        end else begin
          run_mode_next      = 1'b0;
          drive_pattern_next = hssc_pkg::STEP_OFF;
          fault              = 1'b1;
        end
      end
    end else begin
      // speed window; a zero window samples every tick
      if (window_inc >= {1'b0, speed_window}) begin
        speed_value_next  = pos_count - pos_snapshot;
        pos_snapshot_next = pos_count;
        window_count_next = '0;
      end else begin
        window_count_next = window_inc[15:0];
      end

      if ({1'b0, sample.hall_bits} != prev_hall) begin
        prev_hall_next = {1'b0, sample.hall_bits};
        if (run_mode) begin
          mapped_step       = (direction == hssc_pkg::DIR_CW) ? ~sample.hall_bits
                                                              : sample.hall_bits;
          step_current_next = mapped_step;
          if (mapped_step != hssc_pkg::STEP_OFF && mapped_step <= hssc_pkg::STEP_MAX) begin
            drive_pattern_next = mapped_step;
          end else begin
            run_mode_next      = 1'b0;
            drive_pattern_next = hssc_pkg::STEP_OFF;
            fault              = 1'b1;
          end
        end
      end

      if (step_previous != step_current_next) begin
        move = hssc_pkg::classify_move(step_previous, step_current_next);
        case (move)
          hssc_pkg::MOVE_CW:  pos_count_next = pos_count + POSITION_BITS'(1);
          hssc_pkg::MOVE_CCW: pos_count_next = pos_count - POSITION_BITS'(1);
          default:            pos_count_next = pos_count;
        endcase
        step_previous_next = step_current_next;
        dwell_count_next   = '0;
      end else if (dwell_count != 16'hFFFF) begin
        dwell_count_next = dwell_count + 16'd1;
      end
    end
  end

  assign pos_ext   = 64'(signed'(pos_count_next));
  assign speed_ext = 64'(signed'(speed_value_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_window  <= hssc_pkg::SPEED_WINDOW_RESET;
      run_mode      <= 1'b0;
      direction     <= hssc_pkg::DIR_CCW;
      duty_value    <= '0;
      prev_hall     <= hssc_pkg::HALL_NONE_SEEN;
      step_current  <= hssc_pkg::STEP_OFF;
      step_previous <= hssc_pkg::STEP_OFF;
      drive_pattern <= hssc_pkg::STEP_OFF;
      pos_count     <= '0;
      pos_snapshot  <= '0;
      speed_value   <= '0;
      window_count  <= '0;
      dwell_count   <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == hssc_pkg::ADDR_SPEED_WINDOW) begin
        speed_window <= pwdata[15:0];
      end

      if (accept) begin
        run_mode      <= run_mode_next;
        direction     <= direction_next;
        duty_value    <= duty_value_next;
        prev_hall     <= prev_hall_next;
        step_current  <= step_current_next;
        step_previous <= step_previous_next;
        drive_pattern <= drive_pattern_next;
        pos_count     <= pos_count_next;
        pos_snapshot  <= pos_snapshot_next;
        speed_value   <= speed_value_next;
        window_count  <= window_count_next;
        dwell_count   <= dwell_count_next;
        res_valid     <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      result.high_phase  <= hssc_pkg::pair_high(drive_pattern_next);
      result.low_phase   <= hssc_pkg::pair_low(drive_pattern_next);
      result.pwm_compare <= (drive_pattern_next != hssc_pkg::STEP_OFF) ?
                            16'(duty_value_next) : 16'd0;
      result.running     <= run_mode_next;
      result.hall_fault  <= fault;
      result.step_now    <= step_current_next;
      result.position    <= pos_ext[31:0];
      result.speed       <= speed_ext[31:0];
      result.dwell_ticks <= dwell_count_next;
    end
  end

endmodule
